// ----- design/dlc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlc_pkg
// Shared types and constants for the display list coprocessor.
// ----------------------------------------------------------------------------
package dlc_pkg;

    localparam int FETCH_W  = 21;
    localparam int WORD_W   = 16;
    localparam int OFFSET_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;
    localparam int PC_INC_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENHANCED_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_START    = 2'd2;

    // Register offset limits for a legal move
    localparam logic [OFFSET_W-1:0] DANGER_LIMIT = 9'h080;
    localparam logic [OFFSET_W-1:0] ALWAYS_LIMIT = 9'h040;

    // Program counter steps
    localparam logic [PC_INC_W-1:0] PC_INC_NONE = 3'd0;
    localparam logic [PC_INC_W-1:0] PC_INC_WORD = 3'd2;
    localparam logic [PC_INC_W-1:0] PC_INC_SKIP = 3'd6;

    typedef enum logic [4:0] {
        PH_FETCH_FIRST = 5'b00001,
        PH_FETCH_COND  = 5'b00010,
        PH_FETCH_MOVE  = 5'b00100,
        PH_WAIT        = 5'b01000,
        PH_HALT        = 5'b10000
    } t_phase;

    typedef struct packed {
        logic                  danger_enable;
        logic                  enhanced_mode;
        logic [FETCH_W-1:0]    list_start;
    } t_cfg;

    typedef struct packed {
        logic                  restart;
        logic [WORD_W-1:0]     beam_pos;
        logic [WORD_W-1:0]     mem_word;
    } t_in_item;

    typedef struct packed {
        logic [FETCH_W-1:0]    fetch_addr;
        logic                  write_valid;
        logic [OFFSET_W-1:0]   reg_offset;
        logic [WORD_W-1:0]     reg_value;
        logic                  halted;
        logic                  waiting;
    } t_result;

endpackage : dlc_pkg
`default_nettype wire

// ----- design/dlc_beam_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlc_beam_cmp
// Masked beam position compare used by WAIT and SKIP.
// ----------------------------------------------------------------------------
module dlc_beam_cmp
    import dlc_pkg::*;
(
    input  wire logic [WORD_W-1:0] i_beam,
    input  wire logic [WORD_W-1:0] i_pos,
    input  wire logic [WORD_W-1:0] i_mask,
    output logic                   o_pass
);

    logic [7:0] vc, vw;
    logic [6:0] hc, hw;

    // Horizontal bit 0 never takes part in the compare
    assign vc = i_beam[15:8] & i_mask[15:8];
    assign vw = i_pos[15:8]  & i_mask[15:8];
    assign hc = i_beam[7:1]  & i_mask[7:1];
    assign hw = i_pos[7:1]   & i_mask[7:1];

    assign o_pass = (vc > vw) || ((vc == vw) && (hc >= hw));

endmodule : dlc_beam_cmp
`default_nettype wire

// ----- design/dlc_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlc_core
// Instruction sequencer: holds phase, program counter and fetched words,
// and forms one result per step.
// ----------------------------------------------------------------------------
module dlc_core
    import dlc_pkg::*;
#(
    parameter int ADDR_BITS = 21
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_result       o_result
);

    t_phase                r_phase, n_phase;
    logic [ADDR_BITS-1:0]  r_pc, n_pc;
    logic [WORD_W-1:0]     r_first, n_first;
    logic [WORD_W-1:0]     r_second, n_second;

    logic [PC_INC_W-1:0]   pc_inc;
    logic [WORD_W-1:0]     cmp_mask;
    logic                  cmp_pass;
    logic [OFFSET_W-1:0]   move_off;
    logic                  move_bad;
    logic                  wr_valid;

    assign cmp_mask = (r_phase == PH_FETCH_COND) ? i_item.mem_word : r_second;

    dlc_beam_cmp u_cmp (
        .i_beam (i_item.beam_pos),
        .i_pos  (r_first),
        .i_mask (cmp_mask),
        .o_pass (cmp_pass)
    );

    assign move_off = {r_first[8:1], 1'b0};
    assign move_bad = (!i_cfg.danger_enable && (move_off < DANGER_LIMIT)) ||
                      (!i_cfg.enhanced_mode && (move_off < ALWAYS_LIMIT));

    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        pc_inc   = PC_INC_NONE;
        wr_valid = 1'b0;
        if (i_item.restart) begin
            n_phase = PH_FETCH_FIRST;
        end else begin
            unique case (r_phase)
                PH_FETCH_FIRST: begin
                    n_first = i_item.mem_word;
                    pc_inc  = PC_INC_WORD;
                    n_phase = i_item.mem_word[0] ? PH_FETCH_COND : PH_FETCH_MOVE;
                end
                PH_FETCH_COND: begin
                    // WAIT keeps its mask with bit 0 set, SKIP already has it
                    n_second = {i_item.mem_word[WORD_W-1:1], 1'b1};
                    if (i_item.mem_word[0]) begin
                        pc_inc  = cmp_pass ? PC_INC_SKIP : PC_INC_WORD;
                        n_phase = PH_FETCH_FIRST;
                    end else begin
                        pc_inc  = PC_INC_WORD;
                        n_phase = cmp_pass ? PH_FETCH_FIRST : PH_WAIT;
                    end
                end
                PH_FETCH_MOVE: begin
                    n_second = i_item.mem_word;
                    pc_inc   = PC_INC_WORD;
                    if (move_bad) begin
                        n_phase = PH_HALT;
                    end else begin
                        wr_valid = 1'b1;
                        n_phase  = PH_FETCH_FIRST;
                    end
                end
                PH_WAIT: begin
                    if (cmp_pass) begin
                        n_phase = PH_FETCH_FIRST;
                    end
                end
                default: begin
                    // halted, and any stray code, holds until restart
                    n_phase = r_phase;
                end
            endcase
        end
    end

    assign n_pc = i_item.restart ? ADDR_BITS'(i_cfg.list_start)
                                 : r_pc + ADDR_BITS'(pc_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FETCH_FIRST;
            r_pc     <= '0;
            r_first  <= '0;
            r_second <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_pc     <= n_pc;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    always_comb begin
        o_result.fetch_addr  = FETCH_W'(n_pc);
        o_result.write_valid = wr_valid;
        o_result.reg_offset  = wr_valid ? move_off : '0;
        o_result.reg_value   = wr_valid ? i_item.mem_word : '0;
        o_result.waiting     = (n_phase == PH_WAIT);
        o_result.halted      = !((n_phase == PH_FETCH_FIRST) ||
                                 (n_phase == PH_FETCH_COND)  ||
                                 (n_phase == PH_FETCH_MOVE)  ||
                                 (n_phase == PH_WAIT));
    end

endmodule : dlc_core
`default_nettype wire

// ----- design/display_list_coprocessor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// display_list_coprocessor_unit
// Display list coprocessor: fetches two-word MOVE/WAIT/SKIP instructions,
// one tick per transaction while the output accepts, and issues chipset register writes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake               Payload
//  s_axis    in   tvalid/tready           tdata: restart, beam_pos, mem_word
//  m_axis    out  tvalid/tready           tdata: fetch_addr, reg_offset,
//                                         reg_value, halted, waiting;
//                                         tuser: write_valid
//  cfg       in   i_cfg_we (no wait)      index, data
//
//  One transaction per clock sustained while the output is not stalled; each
//  passes the input register, then the sequencer step into the result register.
//  The sequencer state advances once per step, so the step-to-step loop
//  through phase and program counter sets the transaction rate.
//  Synchronous active-low reset returns to fetching the first word at
//  address zero; no clearing pass.
//  A stalled output holds; while the result waits, the input register takes a new item only if it is empty.
// ----------------------------------------------------------------------------
module display_list_coprocessor_unit
    import dlc_pkg::*;
#(
    parameter int ADDR_BITS = 21
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tdata: restart[0], beam_pos[16:1], mem_word[32:17], zero pad [39:33]
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // tdata: fetch_addr[20:0], reg_offset[29:21], reg_value[45:30],
    //        halted[46], waiting[47]
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]       o_m_axis_tdata,
    // tuser: write_valid[0]
    output logic                       o_m_axis_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    t_result  r_result;
    t_result  step_result;
    logic     out_free;
    logic     step;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DANGER_ENABLE: r_cfg.danger_enable <= i_cfg_wdata[0];
                CFG_ENHANCED_MODE: r_cfg.enhanced_mode <= i_cfg_wdata[0];
                CFG_LIST_START:    r_cfg.list_start    <= i_cfg_wdata[FETCH_W-1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_item.restart  <= i_s_axis_tdata[0];
            r_in_item.beam_pos <= i_s_axis_tdata[16:1];
            r_in_item.mem_word <= i_s_axis_tdata[32:17];
        end
    end

    dlc_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_result.write_valid;
    assign o_m_axis_tdata  = {r_result.waiting, r_result.halted, r_result.reg_value,
                              r_result.reg_offset, r_result.fetch_addr};

endmodule : display_list_coprocessor_unit
`default_nettype wire

// ----- design/dlc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlc_checker
// Port-level checks on the coprocessor result stream.
// ----------------------------------------------------------------------------
module dlc_checker
    import dlc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    input  wire logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input  wire logic                  o_m_axis_tuser
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

    // A write always returns to fetching, never to halt or wait
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (!o_m_axis_tdata[46] && !o_m_axis_tdata[47]))
        else $error("write issued while halted or waiting");

    // Written register offsets are always word aligned
    a_write_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> !o_m_axis_tdata[21])
        else $error("illegal register offset written");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
            ((o_m_axis_tdata[29:21] == '0) && (o_m_axis_tdata[45:30] == '0)))
        else $error("write fields nonzero without a write");

    a_halt_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[46] && o_m_axis_tdata[47]))
        else $error("halted and waiting together");

endmodule : dlc_checker

bind display_list_coprocessor_unit dlc_checker u_dlc_checker (.*);
`default_nettype wire
